FILE: rtl/core/gsfc_pkg.sv
// ----------------------------------------------------------------------------
// gsfc_pkg
// Types, codes and the CRC-8 step shared by the gas sensor frame checker.
// ----------------------------------------------------------------------------
package gsfc_pkg;

  localparam int unsigned FRAME_LEN = 6;
  localparam logic [7:0]  CRC_INIT  = 8'hFF;
  localparam logic [7:0]  CRC_POLY  = 8'h31;

  localparam logic [15:0] WARMUP_CO2_RST  = 16'd400;
  localparam logic [15:0] WARMUP_TVOC_RST = 16'd0;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // register indexes
  localparam logic REG_WARMUP_CO2  = 1'b0;
  localparam logic REG_WARMUP_TVOC = 1'b1;

  // request codes
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_ABORT = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // status codes
  localparam logic [2:0] ST_BYTE_TAKEN = 3'd0;
  localparam logic [2:0] ST_FRAME_OK   = 3'd1;
  localparam logic [2:0] ST_CRC_FAIL   = 3'd2;
  localparam logic [2:0] ST_READ_OK    = 3'd3;
  localparam logic [2:0] ST_NO_DATA    = 3'd4;
  localparam logic [2:0] ST_ABORTED    = 3'd5;

  // frame positions
  localparam logic [2:0] POS_CO2_MSB  = 3'd0;
  localparam logic [2:0] POS_CO2_LSB  = 3'd1;
  localparam logic [2:0] POS_CO2_CRC  = 3'd2;
  localparam logic [2:0] POS_TVOC_MSB = 3'd3;
  localparam logic [2:0] POS_TVOC_LSB = 3'd4;
  localparam logic [2:0] POS_TVOC_CRC = 3'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] co2_value;
    logic [15:0] tvoc_value;
    logic        new_data_ready;
    logic        readings_valid;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] warmup_co2;
    logic [15:0] warmup_tvoc;
  } cfg_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/gsfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// gsfc_cfg_regs
// APB register file holding the warm-up reading pair.
// ----------------------------------------------------------------------------
module gsfc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsfc_pkg::CFG_AW-1:0]  paddr,
  input  logic [gsfc_pkg::CFG_DW-1:0]  pwdata,
  output logic [gsfc_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output gsfc_pkg::cfg_t               cfg
);

  gsfc_pkg::cfg_t cfg_r;
  gsfc_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        gsfc_pkg::REG_WARMUP_CO2:  cfg_nxt.warmup_co2  = pwdata[15:0];
        gsfc_pkg::REG_WARMUP_TVOC: cfg_nxt.warmup_tvoc = pwdata[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warmup_co2  <= gsfc_pkg::WARMUP_CO2_RST;
      cfg_r.warmup_tvoc <= gsfc_pkg::WARMUP_TVOC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      gsfc_pkg::REG_WARMUP_CO2:  prdata = {16'd0, cfg_r.warmup_co2};
      gsfc_pkg::REG_WARMUP_TVOC: prdata = {16'd0, cfg_r.warmup_tvoc};
      default:                   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/gas_sensor_frame_checker_core.sv
// ----------------------------------------------------------------------------
// gas_sensor_frame_checker_core
// Checks CRC-8 protected CO2/TVOC frames byte by byte and serves host reads.
// ----------------------------------------------------------------------------
// Each result is registered in the output register, or in the skid register while the output stalls.
// Throughput: one beat per cycle while the skid entry is free; the frame state and CRC update in one pass.
// A two-entry result buffer keeps input open during an output stall until its skid entry is full.
// Reset: synchronous active-low rst_n clears frame state, flags and buffer;
// warm-up registers return to CO2 400, TVOC 0.
module gas_sensor_frame_checker_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gsfc_pkg::in_beat_t           in_beat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gsfc_pkg::out_beat_t          out_beat,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsfc_pkg::CFG_AW-1:0]  paddr,
  input  logic [gsfc_pkg::CFG_DW-1:0]  pwdata,
  output logic [gsfc_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);

  gsfc_pkg::cfg_t cfg;

  gsfc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // frame state
  logic [2:0]  byte_pos_r, byte_pos_nxt;
  logic [7:0]  crc_acc_r, crc_acc_nxt;
  logic [7:0]  high_byte_r, high_byte_nxt;
  logic [15:0] pend_co2_r, pend_co2_nxt;
  logic [15:0] pend_tvoc_r, pend_tvoc_nxt;
  logic        first_ok_r, first_ok_nxt;
  logic [15:0] stored_co2_r, stored_co2_nxt;
  logic [15:0] stored_tvoc_r, stored_tvoc_nxt;
  logic        valid_flag_r, valid_flag_nxt;
  logic        new_flag_r, new_flag_nxt;

  // result buffer
  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  gsfc_pkg::out_beat_t out_beat_r, out_beat_nxt;
  gsfc_pkg::out_beat_t skid_beat_r, skid_beat_nxt;
  gsfc_pkg::out_beat_t res;

  logic       push;
  logic       pop;
  logic [2:0] pos;
  logic [7:0] crc_seed;
  logic [7:0] crc_upd;

  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  assign pos = (byte_pos_r > gsfc_pkg::POS_TVOC_CRC) ? gsfc_pkg::POS_CO2_MSB : byte_pos_r;
  assign crc_seed = (pos == gsfc_pkg::POS_CO2_MSB || pos == gsfc_pkg::POS_TVOC_MSB)
                    ? gsfc_pkg::CRC_INIT : crc_acc_r;
  assign crc_upd = gsfc_pkg::crc8_byte(crc_seed, in_beat.rx_byte);

  always_comb begin
    byte_pos_nxt    = byte_pos_r;
    crc_acc_nxt     = crc_acc_r;
    high_byte_nxt   = high_byte_r;
    pend_co2_nxt    = pend_co2_r;
    pend_tvoc_nxt   = pend_tvoc_r;
    first_ok_nxt    = first_ok_r;
    stored_co2_nxt  = stored_co2_r;
    stored_tvoc_nxt = stored_tvoc_r;
    valid_flag_nxt  = valid_flag_r;
    new_flag_nxt    = new_flag_r;
    res.status      = gsfc_pkg::ST_BYTE_TAKEN;
    res.co2_value   = '0;
    res.tvoc_value  = '0;

    case (in_beat.req_type)
      gsfc_pkg::REQ_BYTE: begin
        byte_pos_nxt = pos + 3'd1;
        case (pos)
          gsfc_pkg::POS_CO2_MSB, gsfc_pkg::POS_TVOC_MSB: begin
            high_byte_nxt = in_beat.rx_byte;
            crc_acc_nxt   = crc_upd;
          end
          gsfc_pkg::POS_CO2_LSB: begin
            pend_co2_nxt = {high_byte_r, in_beat.rx_byte};
            crc_acc_nxt  = crc_upd;
          end
          gsfc_pkg::POS_TVOC_LSB: begin
            pend_tvoc_nxt = {high_byte_r, in_beat.rx_byte};
            crc_acc_nxt   = crc_upd;
          end
          gsfc_pkg::POS_CO2_CRC: begin
            first_ok_nxt = (crc_acc_r == in_beat.rx_byte);
            crc_acc_nxt  = gsfc_pkg::CRC_INIT;
          end
          default: begin
            if (first_ok_r && crc_acc_r == in_beat.rx_byte) begin
              stored_co2_nxt  = pend_co2_r;
              stored_tvoc_nxt = pend_tvoc_r;
              if (pend_co2_r != cfg.warmup_co2 || pend_tvoc_r != cfg.warmup_tvoc) begin
                valid_flag_nxt = 1'b1;
              end
              new_flag_nxt = 1'b1;
              res.status   = gsfc_pkg::ST_FRAME_OK;
            end else begin
              res.status = gsfc_pkg::ST_CRC_FAIL;
            end
            byte_pos_nxt = gsfc_pkg::POS_CO2_MSB;
            crc_acc_nxt  = gsfc_pkg::CRC_INIT;
            first_ok_nxt = 1'b0;
          end
        endcase
      end
      gsfc_pkg::REQ_ABORT: begin
        byte_pos_nxt = gsfc_pkg::POS_CO2_MSB;
        crc_acc_nxt  = gsfc_pkg::CRC_INIT;
        first_ok_nxt = 1'b0;
        res.status   = gsfc_pkg::ST_ABORTED;
      end
      gsfc_pkg::REQ_READ: begin
        if (valid_flag_r) begin
          res.co2_value  = stored_co2_r;
          res.tvoc_value = stored_tvoc_r;
          new_flag_nxt   = 1'b0;
          res.status     = gsfc_pkg::ST_READ_OK;
        end else begin
          res.status = gsfc_pkg::ST_NO_DATA;
        end
      end
      default: res.status = gsfc_pkg::ST_BYTE_TAKEN;
    endcase

    res.new_data_ready = new_flag_nxt;
    res.readings_valid = valid_flag_nxt;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_beat_nxt   = out_beat_r;
    skid_beat_nxt  = skid_beat_r;
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_beat_nxt   = skid_beat_r;
        skid_valid_nxt = push;
        skid_beat_nxt  = res;
      end else begin
        out_valid_nxt = push;
        out_beat_nxt  = res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_beat_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r    <= gsfc_pkg::POS_CO2_MSB;
      crc_acc_r     <= gsfc_pkg::CRC_INIT;
      high_byte_r   <= '0;
      pend_co2_r    <= '0;
      pend_tvoc_r   <= '0;
      first_ok_r    <= 1'b0;
      stored_co2_r  <= '0;
      stored_tvoc_r <= '0;
      valid_flag_r  <= 1'b0;
      new_flag_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      if (push) begin
        byte_pos_r    <= byte_pos_nxt;
        crc_acc_r     <= crc_acc_nxt;
        high_byte_r   <= high_byte_nxt;
        pend_co2_r    <= pend_co2_nxt;
        pend_tvoc_r   <= pend_tvoc_nxt;
        first_ok_r    <= first_ok_nxt;
        stored_co2_r  <= stored_co2_nxt;
        stored_tvoc_r <= stored_tvoc_nxt;
        valid_flag_r  <= valid_flag_nxt;
        new_flag_r    <= new_flag_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r  <= out_beat_nxt;
    skid_beat_r <= skid_beat_nxt;
  end

endmodule

FILE: rtl/core/gsfc_checker.sv
// ----------------------------------------------------------------------------
// gsfc_checker
// Port-level assertions for the gas sensor frame checker, bound to the core.
// ----------------------------------------------------------------------------
module gsfc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input gsfc_pkg::out_beat_t out_beat
);

  logic seen_valid_r;

  // once a result shows readings valid, the flag is sticky
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_valid_r <= 1'b0;
    end else if (out_valid && out_ready && out_beat.readings_valid) begin
      seen_valid_r <= 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("stalled result changed");

  a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_valid_r |-> out_beat.readings_valid)
    else $error("readings valid flag dropped");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.status == gsfc_pkg::ST_READ_OK
    |-> out_beat.readings_valid && !out_beat.new_data_ready)
    else $error("read ok without valid readings or new flag left set");

  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.status == gsfc_pkg::ST_NO_DATA
    |-> !out_beat.readings_valid && out_beat.co2_value == 16'd0
        && out_beat.tvoc_value == 16'd0)
    else $error("no-data result carries readings");

endmodule

bind gas_sensor_frame_checker_core gsfc_checker u_gsfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);

FILE: test/gas_sensor_frame_checker_core_tb.sv
// ----------------------------------------------------------------------------
// gas_sensor_frame_checker_core_tb
// Drives CO2/TVOC frames, aborts and host reads into the frame checker and
// compares every result beat with a cycle-free model of the checker kept in
// a small scoreboard. Warm-up registers are rewritten between phases while
// the block is idle; both channels idle in random bursts except at the end.
// ----------------------------------------------------------------------------
module gas_sensor_frame_checker_core_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         IDLE_LIMIT = 2000;

  class frame_scoreboard;
    logic [15:0]         warm_co2, warm_tvoc;
    logic [2:0]          pos;
    logic [7:0]          crc, msb;
    logic [15:0]         part_co2, part_tvoc;
    logic                co2_crc_ok;
    logic [15:0]         held_co2, held_tvoc;
    logic                valid_f, fresh_f;
    gsfc_pkg::out_beat_t expected_q[$];
    int                  mismatches;

    function new();
      warm_co2   = gsfc_pkg::WARMUP_CO2_RST;
      warm_tvoc  = gsfc_pkg::WARMUP_TVOC_RST;
      pos        = gsfc_pkg::POS_CO2_MSB;
      crc        = gsfc_pkg::CRC_INIT;
      co2_crc_ok = 1'b0;
      msb        = '0;
      part_co2   = '0;
      part_tvoc  = '0;
      held_co2   = '0;
      held_tvoc  = '0;
      valid_f    = 1'b0;
      fresh_f    = 1'b0;
      mismatches = 0;
    endfunction

    // bitwise MSB-first form of the CRC-8 update
    static function logic [7:0] crc_update(logic [7:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c  = {c[6:0], 1'b0} ^ (fb ? gsfc_pkg::CRC_POLY : 8'h00);
      end
      return c;
    endfunction

    function void restart();
      pos        = gsfc_pkg::POS_CO2_MSB;
      crc        = gsfc_pkg::CRC_INIT;
      co2_crc_ok = 1'b0;
    endfunction

    function void note_beat(gsfc_pkg::in_beat_t b);
      gsfc_pkg::out_beat_t r;
      r = '0;
      r.status = gsfc_pkg::ST_BYTE_TAKEN;
      case (b.req_type)
        gsfc_pkg::REQ_BYTE: begin
          case (pos)
            gsfc_pkg::POS_CO2_LSB: begin
              part_co2 = {msb, b.rx_byte};
              crc = crc_update(crc, b.rx_byte);
            end
            gsfc_pkg::POS_TVOC_LSB: begin
              part_tvoc = {msb, b.rx_byte};
              crc = crc_update(crc, b.rx_byte);
            end
            gsfc_pkg::POS_CO2_CRC: begin
              co2_crc_ok = (crc == b.rx_byte);
              crc = gsfc_pkg::CRC_INIT;
            end
            gsfc_pkg::POS_TVOC_CRC: begin
              if (co2_crc_ok && crc == b.rx_byte) begin
                held_co2  = part_co2;
                held_tvoc = part_tvoc;
                if (held_co2 != warm_co2 || held_tvoc != warm_tvoc) valid_f = 1'b1;
                fresh_f  = 1'b1;
                r.status = gsfc_pkg::ST_FRAME_OK;
              end else begin
                r.status = gsfc_pkg::ST_CRC_FAIL;
              end
            end
            default: begin
              // word MSB; out-of-range positions restart the frame here too
              if (pos != gsfc_pkg::POS_TVOC_MSB) pos = gsfc_pkg::POS_CO2_MSB;
              msb = b.rx_byte;
              crc = crc_update(gsfc_pkg::CRC_INIT, b.rx_byte);
            end
          endcase
          if (pos == gsfc_pkg::POS_TVOC_CRC) restart();
          else pos = pos + 3'd1;
        end
        gsfc_pkg::REQ_ABORT: begin
          restart();
          r.status = gsfc_pkg::ST_ABORTED;
        end
        gsfc_pkg::REQ_READ: begin
          if (valid_f) begin
            r.co2_value  = held_co2;
            r.tvoc_value = held_tvoc;
            fresh_f      = 1'b0;
            r.status     = gsfc_pkg::ST_READ_OK;
          end else begin
            r.status = gsfc_pkg::ST_NO_DATA;
          end
        end
        default: ;
      endcase
      r.new_data_ready = fresh_f;
      r.readings_valid = valid_f;
      expected_q.push_back(r);
    endfunction

    function void check_beat(gsfc_pkg::out_beat_t got);
      gsfc_pkg::out_beat_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status=%0d co2=%h tvoc=%h new=%b valid=%b",
                   got.status, got.co2_value, got.tvoc_value, got.new_data_ready,
                   got.readings_valid);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.co2_value !== want.co2_value ||
          got.tvoc_value !== want.tvoc_value ||
          got.new_data_ready !== want.new_data_ready ||
          got.readings_valid !== want.readings_valid) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: exp status=%0d co2=%h tvoc=%h new=%b valid=%b",
                    " | got status=%0d co2=%h tvoc=%h new=%b valid=%b"},
                   want.status, want.co2_value, want.tvoc_value, want.new_data_ready,
                   want.readings_valid, got.status, got.co2_value, got.tvoc_value,
                   got.new_data_ready, got.readings_valid);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  gsfc_pkg::in_beat_t            in_beat;
  logic                          out_valid;
  logic                          out_ready;
  gsfc_pkg::out_beat_t           out_beat;
  logic                          psel, penable, pwrite;
  logic [gsfc_pkg::CFG_AW-1:0]   paddr;
  logic [gsfc_pkg::CFG_DW-1:0]   pwdata;
  logic [gsfc_pkg::CFG_DW-1:0]   prdata;
  logic                          pready;

  frame_scoreboard sb;
  bit              gaps_on;
  int              beats_sent;
  int              quiet_cycles;

  gas_sensor_frame_checker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_beat(out_beat);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result-side back-pressure
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_beat(logic [1:0] req, logic [7:0] data);
    gsfc_pkg::in_beat_t b;
    b.req_type = req;
    b.rx_byte  = data;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_beat(b);
    if (req != REQ_UNUSED) beats_sent++;
  endtask

  task automatic send_frame(logic [15:0] co2, logic [15:0] tvoc, bit bad_co2, bit bad_tvoc,
                            int keep);
    logic [7:0] seq[6];
    seq[0] = co2[15:8];
    seq[1] = co2[7:0];
    seq[2] = frame_scoreboard::crc_update(
               frame_scoreboard::crc_update(gsfc_pkg::CRC_INIT, co2[15:8]), co2[7:0]);
    seq[3] = tvoc[15:8];
    seq[4] = tvoc[7:0];
    seq[5] = frame_scoreboard::crc_update(
               frame_scoreboard::crc_update(gsfc_pkg::CRC_INIT, tvoc[15:8]), tvoc[7:0]);
    if (bad_co2)  seq[2] = seq[2] ^ (8'h01 << $urandom_range(0, 7));
    if (bad_tvoc) seq[5] = seq[5] ^ (8'h01 << $urandom_range(0, 7));
    for (int i = 0; i < keep; i++) send_beat(gsfc_pkg::REQ_BYTE, seq[i]);
    if (keep < 6) send_beat(gsfc_pkg::REQ_ABORT, 8'($urandom));
  endtask

  task automatic settle_and_write(logic [15:0] co2_w, logic [15:0] tvoc_w);
    logic [15:0] vals[2];
    logic        idx[2];
    vals[0] = co2_w;
    vals[1] = tvoc_w;
    idx[0]  = gsfc_pkg::REG_WARMUP_CO2;
    idx[1]  = gsfc_pkg::REG_WARMUP_TVOC;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    for (int i = 0; i < 2; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx[i], 2'b00};
      pwdata  <= {16'h0000, vals[i]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (idx[i] == gsfc_pkg::REG_WARMUP_CO2) sb.warm_co2 = vals[i];
      else sb.warm_tvoc = vals[i];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word(logic [15:0] warm);
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return warm;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    int goal;
    goal = beats_sent + count;
    while (beats_sent < goal) begin
      case ($urandom_range(0, 19))
        0, 1, 2: send_beat(gsfc_pkg::REQ_READ, 8'($urandom));
        3:       send_beat(gsfc_pkg::REQ_ABORT, 8'($urandom));
        4:       send_beat(REQ_UNUSED, 8'($urandom));
        5:       send_beat(gsfc_pkg::REQ_BYTE, 8'($urandom));
        default: begin
          if ($urandom_range(0, 3) == 0) send_beat(gsfc_pkg::REQ_ABORT, 8'($urandom));
          send_frame(pick_word(sb.warm_co2), pick_word(sb.warm_tvoc),
                     $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 6);
        end
      endcase
    end
  endtask

  initial begin
    int fails;
    sb         = new();
    gaps_on    = 1'b1;
    beats_sent = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_beat    <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    settle_and_write(16'd400, 16'd0);
    send_beat(gsfc_pkg::REQ_READ, 8'h00);
    send_beat(gsfc_pkg::REQ_ABORT, 8'hFF);
    send_beat(REQ_UNUSED, 8'hFF);
    send_frame(16'd400, 16'd0, 1'b0, 1'b0, 6);
    send_beat(gsfc_pkg::REQ_READ, 8'hFF);
    send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 6);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 6);
    send_beat(gsfc_pkg::REQ_READ, 8'h00);
    send_beat(gsfc_pkg::REQ_READ, 8'h00);
    send_frame(16'h00FF, 16'hFF00, 1'b1, 1'b0, 2);

    settle_and_write(16'h0000, 16'h0000);
    random_phase(225);
    settle_and_write(16'hFFFF, 16'hFFFF);
    random_phase(225);
    settle_and_write(16'($urandom), 16'($urandom));
    random_phase(225);
    settle_and_write(16'd400, 16'($urandom));
    gaps_on = 1'b0;
    random_phase(225);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    fails = sb.mismatches + sb.expected_q.size();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
